@@ src/csgtb_pkg.sv @@
// ============================================================================
// csgtb_pkg
// Shared types and constants of the clock-synced gate toggle bank.
// ============================================================================
`default_nettype none

package csgtb_pkg;

	localparam int ChannelCount = 8;
	localparam int PortWidth = 8;
	localparam int PulseWidth = 10;
	localparam int CfgIndexWidth = 2;
	localparam int CfgDataWidth = 10;
	localparam logic [PulseWidth-1:0] PulseTicksReset = 10'd48;

	typedef enum logic [CfgIndexWidth-1:0] {
		CFG_DISABLE_UNARM = 2'd0,
		CFG_PULSE_TICKS = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WAIT_GATE = 2'd1,
		MODE_GATING = 2'd2,
		MODE_WAIT_IDLE = 2'd3
	} mode_t;

	typedef struct packed {
		logic [PortWidth-1:0] clock_high;
		logic [PortWidth-1:0] clock_plugged;
		logic [PortWidth-1:0] arm_high;
		logic [PortWidth-1:0] reset_high;
		logic [PortWidth-1:0] reset_plugged;
		logic reset_all_high;
	} item_t;

	typedef struct packed {
		logic [PortWidth-1:0] gate_out;
		logic [PortWidth-1:0] trigger_out;
		logic [PortWidth-1:0] change_pending;
	} result_t;

	typedef struct packed {
		logic clock_high;
		logic clock_plugged;
		logic arm_high;
		logic reset_high;
		logic reset_plugged;
	} pins_t;

	typedef struct packed {
		logic step;
		logic reset_all_edge;
		logic disable_unarm;
		logic [PulseWidth-1:0] pulse_ticks;
	} ctl_t;

	typedef struct packed {
		logic gate;
		logic trigger;
		logic pending;
	} status_t;

endpackage

`default_nettype wire

@@ src/clock_synced_gate_toggle_bank.sv @@
// ============================================================================
// clock_synced_gate_toggle_bank
// Bank of clock-synchronized gate toggles with trigger pulse outputs.
// ============================================================================
// Each accepted item is one sample tick for all channels and produces one
// result. The block takes one item per clock cycle unless a stalled result
// has both registers full. An accepted item is held in the input register
// until the result register can take its result, and the result is then
// captured in the result register and presented. A stalled result holds
// the input register, and the input side stalls only when both registers
// are full. The longest path is the ripple of the clock level through
// channels with unplugged clock jacks, one mux per channel.
`default_nettype none

module clock_synced_gate_toggle_bank #(
	parameter int CHANNEL_COUNT = csgtb_pkg::ChannelCount
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output logic                                      item_ready,
	input  wire csgtb_pkg::item_t                     item,
	output logic                                      result_valid,
	input  wire logic                                 result_ready,
	output csgtb_pkg::result_t                        result,
	input  wire logic                                 cfg_we,
	input  wire logic [csgtb_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  wire logic [csgtb_pkg::CfgDataWidth-1:0]   cfg_data
);

	localparam int PW = csgtb_pkg::PortWidth;

	csgtb_pkg::item_t item_s1;
	logic valid_s1;
	csgtb_pkg::result_t result_s2;
	logic valid_s2;
	logic advance;
	logic last_reset_all_q;
	logic disable_unarm_q;
	logic [csgtb_pkg::PulseWidth-1:0] pulse_ticks_q;
	csgtb_pkg::ctl_t ctl;
	csgtb_pkg::status_t status [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] level;
	logic [CHANNEL_COUNT-1:0] held_level;
	csgtb_pkg::result_t result_next;

	assign advance = !valid_s2 || result_ready;
	assign item_ready = !valid_s1 || advance;
	assign result_valid = valid_s2;
	assign result = result_s2;

	assign ctl.step = valid_s1 && advance;
	assign ctl.reset_all_edge = item_s1.reset_all_high && !last_reset_all_q;
	assign ctl.disable_unarm = disable_unarm_q;
	assign ctl.pulse_ticks = pulse_ticks_q;

	for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_chan
		csgtb_pkg::pins_t pins;
		logic prev_level;

		if (i < PW) begin : g_pins
			assign pins.clock_high = item_s1.clock_high[i];
			assign pins.clock_plugged = item_s1.clock_plugged[i];
			assign pins.arm_high = item_s1.arm_high[i];
			assign pins.reset_high = item_s1.reset_high[i];
			assign pins.reset_plugged = item_s1.reset_plugged[i];
		end else begin : g_nopins
			assign pins = '0;
		end

		if (i == 0) begin : g_first
			assign prev_level = held_level[0];
		end else begin : g_rest
			assign prev_level = level[i-1];
		end

		csgtb_channel u_channel (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.pins       (pins),
			.prev_level (prev_level),
			.level      (level[i]),
			.held_level (held_level[i]),
			.status     (status[i])
		);
	end

	for (genvar j = 0; j < PW; j++) begin : g_out
		if (j < CHANNEL_COUNT) begin : g_used
			assign result_next.gate_out[j] = status[j].gate;
			assign result_next.trigger_out[j] = status[j].trigger;
			assign result_next.change_pending[j] = status[j].pending;
		end else begin : g_unused
			assign result_next.gate_out[j] = 1'b0;
			assign result_next.trigger_out[j] = 1'b0;
			assign result_next.change_pending[j] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disable_unarm_q <= 1'b0;
			pulse_ticks_q <= csgtb_pkg::PulseTicksReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csgtb_pkg::CFG_DISABLE_UNARM: disable_unarm_q <= cfg_data[0];
				csgtb_pkg::CFG_PULSE_TICKS:
					pulse_ticks_q <= cfg_data[csgtb_pkg::PulseWidth-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			last_reset_all_q <= 1'b0;
		end else begin
			if (item_ready) valid_s1 <= item_valid;
			if (ctl.step) begin
				valid_s2 <= 1'b1;
				last_reset_all_q <= item_s1.reset_all_high;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) item_s1 <= item;
		if (ctl.step) result_s2 <= result_next;
	end

endmodule

`default_nettype wire

@@ src/csgtb_channel.sv @@
// ============================================================================
// csgtb_channel
// One channel: edge detection, gate state machine and trigger pulse counter.
// ============================================================================
`default_nettype none

module csgtb_channel (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire csgtb_pkg::ctl_t     ctl,
	input  wire csgtb_pkg::pins_t    pins,
	input  wire logic                prev_level,
	output logic                     level,
	output logic                     held_level,
	output csgtb_pkg::status_t       status
);

	csgtb_pkg::mode_t mode_q;
	csgtb_pkg::mode_t mode_rst;
	csgtb_pkg::mode_t mode_next;
	logic last_clock_q;
	logic last_arm_q;
	logic last_reset_q;
	logic [csgtb_pkg::PulseWidth-1:0] pulse_q;
	logic [csgtb_pkg::PulseWidth-1:0] pulse_cur;
	logic [csgtb_pkg::PulseWidth-1:0] pulse_next;
	logic clk_edge;
	logic arm_edge;
	logic reset_edge;
	logic load_reset;
	logic load_fsm;

	assign held_level = last_clock_q;
	assign level = pins.clock_plugged ? pins.clock_high : prev_level;
	assign clk_edge = level & ~last_clock_q;
	assign arm_edge = pins.arm_high & ~last_arm_q;
	assign reset_edge = pins.reset_plugged & pins.reset_high & ~last_reset_q;

	// Reset-all acts first, then the channel reset; each fires the pulse when it
	// leaves the gating state.
	always_comb begin
		csgtb_pkg::mode_t m1;
		m1 = mode_q;
		load_reset = 1'b0;
		if (ctl.reset_all_edge) begin
			if (m1 == csgtb_pkg::MODE_GATING) load_reset = 1'b1;
			m1 = csgtb_pkg::MODE_IDLE;
		end
		if (reset_edge) begin
			if (m1 == csgtb_pkg::MODE_GATING) load_reset = 1'b1;
			m1 = csgtb_pkg::MODE_IDLE;
		end
		mode_rst = m1;
	end

	always_comb begin
		mode_next = mode_rst;
		load_fsm = 1'b0;
		unique case (mode_rst)
			csgtb_pkg::MODE_IDLE: begin
				if (arm_edge) mode_next = csgtb_pkg::MODE_WAIT_GATE;
			end
			csgtb_pkg::MODE_WAIT_GATE: begin
				if (arm_edge && !ctl.disable_unarm) begin
					mode_next = csgtb_pkg::MODE_IDLE;
				end else if (clk_edge) begin
					mode_next = csgtb_pkg::MODE_GATING;
					load_fsm = 1'b1;
				end
			end
			csgtb_pkg::MODE_GATING: begin
				if (arm_edge) mode_next = csgtb_pkg::MODE_WAIT_IDLE;
			end
			csgtb_pkg::MODE_WAIT_IDLE: begin
				if (arm_edge && !ctl.disable_unarm) begin
					mode_next = csgtb_pkg::MODE_GATING;
				end else if (clk_edge) begin
					mode_next = csgtb_pkg::MODE_IDLE;
					load_fsm = 1'b1;
				end
			end
			default: mode_next = csgtb_pkg::MODE_IDLE;
		endcase
	end

	always_comb begin
		pulse_cur = (load_reset || load_fsm) ? ctl.pulse_ticks : pulse_q;
		status.trigger = (pulse_cur != '0);
		pulse_next = status.trigger ? pulse_cur - csgtb_pkg::PulseWidth'(1) : pulse_cur;
		status.gate = (mode_next == csgtb_pkg::MODE_GATING) ||
			(mode_next == csgtb_pkg::MODE_WAIT_IDLE);
		status.pending = (mode_next == csgtb_pkg::MODE_WAIT_GATE) ||
			(mode_next == csgtb_pkg::MODE_WAIT_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= csgtb_pkg::MODE_IDLE;
			last_clock_q <= 1'b0;
			last_arm_q <= 1'b0;
			last_reset_q <= 1'b0;
			pulse_q <= '0;
		end else if (ctl.step) begin
			mode_q <= mode_next;
			last_clock_q <= level;
			last_arm_q <= pins.arm_high;
			if (pins.reset_plugged) last_reset_q <= pins.reset_high;
			pulse_q <= pulse_next;
		end
	end

endmodule

`default_nettype wire
